FILE: src/assert_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Implication checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: src/swds_pkg.sv
package swds_pkg;

    localparam int LENGTH_BITS  = 16;
    localparam int HEADER_BYTES = 8;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] HDR = LENGTH_BITS'(HEADER_BYTES);
    localparam logic [13:0] MP_RESET = 14'd1024;
    localparam logic [15:0] RT_RESET = 16'd1000;
    localparam logic [13:0] MP_MAX = 14'd8192;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        REQ_SUBMIT_REL   = 2'd0,
        REQ_SUBMIT_UNREL = 2'd1,
        REQ_PACKET       = 2'd2,
        REQ_TICK         = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        K_TX_FRAG    = 5'd0,
        K_RETX       = 5'd1,
        K_TX_UNREL   = 5'd2,
        K_TX_ACK     = 5'd3,
        K_DLV_UNREL  = 5'd4,
        K_DLV_MSG    = 5'd5,
        K_FRAG_STORE = 5'd6,
        K_SEND_DONE  = 5'd7,
        K_NOT_PEER   = 5'd8,
        K_SHORT      = 5'd9,
        K_CTL        = 5'd10,
        K_STALE_UNR  = 5'd11,
        K_STALE_ACK  = 5'd12,
        K_DUP_ACK    = 5'd13,
        K_DUP_DATA   = 5'd14,
        K_NO_ACTION  = 5'd15,
        K_REJECT     = 5'd16
    } kind_t;

    // Classes the front end assigns to each item.
    typedef enum logic [3:0] {
        C_SUB_REL, C_SUB_UNREL, C_UNREL_REJ, C_TICK, C_NOT_PEER,
        C_SHORT, C_CTL, C_UNREL_PKT, C_ACK, C_DATA, C_NONE
    } cls_t;

    typedef enum logic {
        OS_FIRST  = 1'b0,
        OS_SECOND = 1'b1
    } ostate_t;

    typedef struct packed {
        cls_t                   cls;
        logic [15:0]            mlen;
        logic [LENGTH_BITS-1:0] pay;
        logic                   eom;
        logic [31:0]            seq;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] sequence_n;
        logic [15:0] length;
        logic        eom;
        logic [15:0] offset;
        logic        can_send;
        logic [31:0] dropped_gap;
        logic        last;
    } res_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

endpackage

FILE: src/swds_if.sv
interface swds_in_if;
    import swds_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] msg_length;
    logic        rx_from_peer;
    logic [15:0] rx_read_length;
    logic [15:0] rx_header_length;
    logic        rx_ctl;
    logic        rx_unreliable;
    logic        rx_ack;
    logic        rx_data;
    logic        rx_eom;
    logic [31:0] rx_sequence;
    modport source (output valid, req_type, msg_length, rx_from_peer, rx_read_length,
        rx_header_length, rx_ctl, rx_unreliable, rx_ack, rx_data, rx_eom, rx_sequence,
        input ready);
    modport sink (input valid, req_type, msg_length, rx_from_peer, rx_read_length,
        rx_header_length, rx_ctl, rx_unreliable, rx_ack, rx_data, rx_eom, rx_sequence,
        output ready);
endinterface

interface swds_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_kind;
    logic [31:0] out_sequence;
    logic [15:0] out_length;
    logic        out_eom;
    logic [15:0] out_offset;
    logic        can_send;
    logic [31:0] dropped_gap;
    logic        last;
    modport source (output valid, out_kind, out_sequence, out_length, out_eom, out_offset,
        can_send, dropped_gap, last, input ready);
    modport sink (input valid, out_kind, out_sequence, out_length, out_eom, out_offset,
        can_send, dropped_gap, last, output ready);
endinterface

interface swds_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/swds_front.sv
module swds_front
    import swds_pkg::*;
(
    swds_in_if.sink      in_ch,
    output logic         cmd_valid,
    output cmd_t         cmd,
    input  logic         cmd_ready
);

    cmd_t                   c;
    logic [LENGTH_BITS-1:0] hlen;

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign hlen        = in_ch.rx_header_length[LENGTH_BITS-1:0];

    // Classify the item on its request and receive fields alone; no state is needed here.
    always_comb
    begin
        c.mlen = in_ch.msg_length;
        c.pay  = (hlen >= HDR) ? hlen - HDR : '0;
        c.eom  = in_ch.rx_eom;
        c.seq  = in_ch.rx_sequence;
        case (req_t'(in_ch.req_type))
            REQ_SUBMIT_REL:   c.cls = C_SUB_REL;
            REQ_SUBMIT_UNREL: c.cls = ({{(32-16){1'b0}}, in_ch.msg_length} >
                                       32'(LEN_MAX - HDR)) ? C_UNREL_REJ : C_SUB_UNREL;
            REQ_TICK:         c.cls = C_TICK;
            default:
            begin
                if (!in_ch.rx_from_peer)                 c.cls = C_NOT_PEER;
                else if (in_ch.rx_read_length < 16'(HEADER_BYTES)) c.cls = C_SHORT;
                else if (in_ch.rx_ctl)                   c.cls = C_CTL;
                else if (in_ch.rx_unreliable)            c.cls = C_UNREL_PKT;
                else if (in_ch.rx_ack)                   c.cls = C_ACK;
                else if (in_ch.rx_data)                  c.cls = C_DATA;
                else                                     c.cls = C_NONE;
            end
        endcase
    end

    assign cmd = c;

endmodule

FILE: src/swds_queue.sv
module swds_queue
    import swds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_data,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_data,
    input  logic out_ready
);

    `include "assert_macros.svh"

    cmd_t       mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'(QDEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    `ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= 2'(QDEPTH), "queue overfilled")
    `ASSERT_NEXT(a_q_push, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1,
        "queue count did not grow")
    `ASSERT_IMPL(a_q_ptr, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'(QDEPTH),
        wp_reg == rp_reg, "queue pointers disagree with count")

endmodule

FILE: src/swds_back.sv
module swds_back
    import swds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_ready,
    swds_cfg_if.sink  cfg,
    swds_out_if.source out_ch
);

    `include "assert_macros.svh"

    logic [13:0] mp_reg;
    logic [15:0] rt_reg;
    logic [31:0] send_seq_reg, send_seq_next, ack_seq_reg, ack_seq_next;
    logic [31:0] us_seq_reg, us_seq_next, rs_seq_reg, rs_seq_next;
    logic [31:0] ur_seq_reg, ur_seq_next;
    logic [15:0] rem_reg, rem_next, off_reg, off_next;
    logic        idle_reg, idle_next;
    logic [15:0] acc_reg, acc_next, tk_reg, tk_next;

    ostate_t     os_reg, os_next;
    res_t        ob_reg, ob_next, hold_reg, hold_next;
    logic        ov_reg, ov_next;
    logic        take;
    res_t        r0, r1;
    logic        two;
    logic [15:0] lim, frag_rem, lim_new;
    logic        eom_cur, eom_new;
    logic [16:0] sum;
    logic [15:0] sat;
    logic [31:0] sm1;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg <= MP_RESET;
            rt_reg <= RT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == 1'b0) mp_reg <= cfg.data[13:0];
            else                   rt_reg <= cfg.data;
        end
    end

    // Effective payload limit.
    always_comb
    begin
        lim = {2'b0, mp_reg};
        if (mp_reg == 14'd0) lim = 16'd1;
        if (mp_reg > MP_MAX) lim = 16'(MP_MAX);
        if (lim > LEN_MAX - HDR) lim = LEN_MAX - HDR;
    end

    // A new item is taken when the output stage is free or drains now and
    // no second result is still pending.
    assign take      = cmd_valid && (os_reg == OS_FIRST) && (!ov_reg || out_ch.ready);
    assign cmd_ready = take;
    assign sm1       = send_seq_reg - 32'd1;
    assign eom_cur   = rem_reg <= lim;
    assign frag_rem  = rem_reg - lim;
    assign eom_new   = frag_rem <= lim;
    assign lim_new   = eom_new ? frag_rem : lim;
    assign sum       = {1'b0, acc_reg} + {1'b0, cmd.pay};
    assign sat       = sum[16] ? 16'hFFFF : sum[15:0];

    // State update and results of one item.
    always_comb
    begin
        send_seq_next = send_seq_reg;
        ack_seq_next  = ack_seq_reg;
        us_seq_next   = us_seq_reg;
        rs_seq_next   = rs_seq_reg;
        ur_seq_next   = ur_seq_reg;
        rem_next      = rem_reg;
        off_next      = off_reg;
        idle_next     = idle_reg;
        acc_next      = acc_reg;
        tk_next       = tk_reg;
        r0            = '0;
        r1            = '0;
        two           = 1'b0;
        r0.kind       = K_NO_ACTION;
        case (cmd.cls)
            C_SUB_REL:
            begin
                if (!idle_reg) r0.kind = K_REJECT;
                else
                begin
                    rem_next      = cmd.mlen;
                    off_next      = '0;
                    idle_next     = 1'b0;
                    tk_next       = '0;
                    r0.kind       = K_TX_FRAG;
                    r0.sequence_n = send_seq_reg;
                    r0.eom        = cmd.mlen <= lim;
                    r0.length     = HDR + ((cmd.mlen <= lim) ? cmd.mlen : lim);
                    send_seq_next = send_seq_reg + 32'd1;
                end
            end
            C_SUB_UNREL:
            begin
                r0.kind       = K_TX_UNREL;
                r0.sequence_n = us_seq_reg;
                r0.length     = HDR + cmd.mlen;
                us_seq_next   = us_seq_reg + 32'd1;
            end
            C_UNREL_REJ: r0.kind = K_REJECT;
            C_TICK:
            begin
                if (!idle_reg && tk_reg >= rt_reg)
                begin
                    r0.kind       = K_RETX;
                    r0.sequence_n = sm1;
                    r0.eom        = eom_cur;
                    r0.length     = HDR + (eom_cur ? rem_reg : lim);
                    r0.offset     = off_reg;
                    tk_next       = '0;
                end
                else if (!idle_reg) tk_next = tk_reg + 16'd1;
            end
            C_NOT_PEER: r0.kind = K_NOT_PEER;
            C_SHORT:    r0.kind = K_SHORT;
            C_CTL:      r0.kind = K_CTL;
            C_UNREL_PKT:
            begin
                r0.sequence_n = cmd.seq;
                if (cmd.seq < ur_seq_reg) r0.kind = K_STALE_UNR;
                else
                begin
                    r0.kind        = K_DLV_UNREL;
                    r0.length      = cmd.pay;
                    r0.dropped_gap = cmd.seq - ur_seq_reg;
                    ur_seq_next    = cmd.seq + 32'd1;
                end
            end
            C_ACK:
            begin
                r0.sequence_n = cmd.seq;
                if (cmd.seq != sm1)         r0.kind = K_STALE_ACK;
                else if (cmd.seq != ack_seq_reg) r0.kind = K_DUP_ACK;
                else
                begin
                    ack_seq_next = ack_seq_reg + 32'd1;
                    if (!eom_cur)
                    begin
                        rem_next      = frag_rem;
                        off_next      = off_reg + lim;
                        tk_next       = '0;
                        r0.kind       = K_TX_FRAG;
                        r0.sequence_n = send_seq_reg;
                        r0.eom        = eom_new;
                        r0.length     = HDR + lim_new;
                        r0.offset     = off_reg + lim;
                        send_seq_next = send_seq_reg + 32'd1;
                    end
                    else
                    begin
                        rem_next  = '0;
                        idle_next = 1'b1;
                        r0.kind   = K_SEND_DONE;
                    end
                end
            end
            C_DATA:
            begin
                two           = 1'b1;
                r0.kind       = K_TX_ACK;
                r0.sequence_n = cmd.seq;
                r0.length     = HDR;
                r1.sequence_n = cmd.seq;
                if (cmd.seq != rs_seq_reg) r1.kind = K_DUP_DATA;
                else
                begin
                    rs_seq_next = rs_seq_reg + 32'd1;
                    r1.length   = sat;
                    if (cmd.eom)
                    begin
                        r1.kind  = K_DLV_MSG;
                        acc_next = '0;
                    end
                    else
                    begin
                        r1.kind  = K_FRAG_STORE;
                        acc_next = sat;
                    end
                end
            end
            default: r0.sequence_n = cmd.seq;
        endcase
        r0.can_send = idle_next;
        r1.can_send = idle_next;
        r0.last     = !two;
        r1.last     = 1'b1;
    end

    // Output stage sequencing: next state.
    always_comb
    begin
        os_next = os_reg;
        case (os_reg)
            OS_FIRST:  if (take && two) os_next = OS_SECOND;
            OS_SECOND: if (out_ch.ready) os_next = OS_FIRST;
            default:   os_next = OS_FIRST;
        endcase
    end

    // Output stage sequencing: register loads.
    always_comb
    begin
        ob_next   = ob_reg;
        hold_next = hold_reg;
        ov_next   = ov_reg && !out_ch.ready;
        case (os_reg)
            OS_FIRST:
            begin
                if (take)
                begin
                    ob_next   = r0;
                    hold_next = r1;
                    ov_next   = 1'b1;
                end
            end
            OS_SECOND:
            begin
                if (out_ch.ready)
                begin
                    ob_next = hold_reg;
                    ov_next = 1'b1;
                end
            end
            default: ov_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_seq_reg <= '0;
            ack_seq_reg  <= '0;
            us_seq_reg   <= '0;
            rs_seq_reg   <= '0;
            ur_seq_reg   <= '0;
            rem_reg      <= '0;
            off_reg      <= '0;
            idle_reg     <= 1'b1;
            acc_reg      <= '0;
            tk_reg       <= '0;
            os_reg       <= OS_FIRST;
            ov_reg       <= 1'b0;
        end
        else
        begin
            os_reg <= os_next;
            ov_reg <= ov_next;
            if (take)
            begin
                send_seq_reg <= send_seq_next;
                ack_seq_reg  <= ack_seq_next;
                us_seq_reg   <= us_seq_next;
                rs_seq_reg   <= rs_seq_next;
                ur_seq_reg   <= ur_seq_next;
                rem_reg      <= rem_next;
                off_reg      <= off_next;
                idle_reg     <= idle_next;
                acc_reg      <= acc_next;
                tk_reg       <= tk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg   <= ob_next;
        hold_reg <= hold_next;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.out_kind     = ob_reg.kind;
    assign out_ch.out_sequence = ob_reg.sequence_n;
    assign out_ch.out_length   = ob_reg.length;
    assign out_ch.out_eom      = ob_reg.eom;
    assign out_ch.out_offset   = ob_reg.offset;
    assign out_ch.can_send     = ob_reg.can_send;
    assign out_ch.dropped_gap  = ob_reg.dropped_gap;
    assign out_ch.last         = ob_reg.last;

    `ASSERT_IMPL(a_b_second, clk, rst_n, os_reg == OS_SECOND, ov_reg && !ob_reg.last,
        "second result pending without first shown")
    `ASSERT_IMPL(a_b_idle, clk, rst_n, idle_reg, rem_reg == 16'd0,
        "idle sender still has bytes outstanding")
    `ASSERT_NEXT(a_b_take, clk, rst_n, take, ov_reg, "taken item shows no result")

endmodule

FILE: src/stop_and_wait_datagram_sequencer.sv
// Path: an accepted item waits in the queue, then its result is loaded
// into the output register; a second result of a data packet waits in the
// hold register and follows once the first has been taken.
// Throughput: one item per cycle while the output is ready; a data packet
// keeps the back end busy until its second result is taken, so a run of
// data packets fills the two-entry queue, which then holds off the input.
// Reset: rst_n is asynchronous, active low; all sequence state clears and
// the sender comes up idle with max_payload 1024 and resend_ticks 1000.
module stop_and_wait_datagram_sequencer
    import swds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swds_in_if.sink     in_ch,
    swds_cfg_if.sink    cfg,
    swds_out_if.source  out_ch
);

    logic f_valid, f_ready, q_valid, q_ready;
    cmd_t f_cmd, q_cmd;

    swds_front u_front (.in_ch(in_ch), .cmd_valid(f_valid), .cmd(f_cmd),
        .cmd_ready(f_ready));

    swds_queue u_queue (.clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_data(f_cmd),
        .in_ready(f_ready), .out_valid(q_valid), .out_data(q_cmd), .out_ready(q_ready));

    swds_back u_back (.clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd(q_cmd),
        .cmd_ready(q_ready), .cfg(cfg), .out_ch(out_ch));

endmodule
